@@ rtl/pic_pkg.sv @@
// Shared types and constants for the pulse input counter with snapshot.
// No dependencies; used by pic_lane, pic_timebase and the top level.
package pic_pkg;

  localparam int unsigned NumOutputs  = 8;
  localparam int unsigned OutBits     = 16;
  localparam int unsigned DivBits     = 8;
  localparam int unsigned CfgIdxBits  = 4;
  localparam int unsigned CfgDataBits = 8;

  localparam logic [DivBits-1:0] TicksPerTenthReset   = 8'd10;
  localparam logic [DivBits-1:0] TenthsPerSecondReset = 8'd10;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgTicksPerTenth   = 4'd0,
    CfgTenthsPerSecond = 4'd1
  } cfg_idx_e;

  typedef enum logic {
    CmdSample = 1'b0,
    CmdTick   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                   we;
    logic [CfgIdxBits-1:0]  idx;
    logic [CfgDataBits-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic sample;
    logic clear;
  } lane_ctrl_t;

endpackage

@@ rtl/pic_lane.sv @@
// One counting lane: arm flag, edge-triggered pulse counter, clear on snapshot.
// Depends on pic_pkg.
module pic_lane #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pic_pkg::lane_ctrl_t           ctrl_i,
  input  logic                          pin_i,
  output logic [pic_pkg::OutBits-1:0]   snap_o
);

  logic                  armed_q, armed_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  always_comb begin
    armed_d = armed_q;
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.sample) begin
      // pin low is active: count once, then wait for release
      if (!pin_i) begin
        if (!armed_q) begin
          armed_d = 1'b1;
          count_d = count_q + 1'b1;
        end
      end else begin
        armed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      count_q <= '0;
    end else begin
      armed_q <= armed_d;
      count_q <= count_d;
    end
  end

  if (COUNT_BITS >= pic_pkg::OutBits) begin : g_trunc
    assign snap_o = count_q[pic_pkg::OutBits-1:0];
  end else begin : g_ext
    assign snap_o = {{(pic_pkg::OutBits - COUNT_BITS){1'b0}}, count_q};
  end

endmodule

@@ rtl/pic_timebase.sv @@
// Tick and tenth dividers with their configuration registers; flags period end.
// Depends on pic_pkg.
module pic_timebase (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pic_pkg::cfg_wr_t cfg_i,
  input  logic             tick_i,
  output logic             emit_o
);

  logic [pic_pkg::DivBits-1:0] tpt_q, tpt_d;
  logic [pic_pkg::DivBits-1:0] tps_q, tps_d;
  logic [pic_pkg::DivBits-1:0] tick_q, tick_d;
  logic [pic_pkg::DivBits-1:0] tenth_q, tenth_d;
  logic [pic_pkg::DivBits-1:0] tick_inc;
  logic [pic_pkg::DivBits-1:0] tenth_new;

  always_comb begin
    tpt_d = tpt_q;
    tps_d = tps_q;
    if (cfg_i.we) begin
      unique case (cfg_i.idx)
        pic_pkg::CfgTicksPerTenth:   tpt_d = cfg_i.data;
        pic_pkg::CfgTenthsPerSecond: tps_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    tick_inc  = tick_q + 1'b1;
    tick_d    = tick_q;
    tenth_new = tenth_q;
    tenth_d   = tenth_q;
    emit_o    = 1'b0;
    if (tick_i) begin
      tick_d = tick_inc;
      if (tick_inc >= tpt_q) begin
        tick_d    = '0;
        tenth_new = tenth_q + 1'b1;
      end
      tenth_d = tenth_new;
      if (tenth_new >= tps_q) begin
        tenth_d = '0;
        emit_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpt_q   <= pic_pkg::TicksPerTenthReset;
      tps_q   <= pic_pkg::TenthsPerSecondReset;
      tick_q  <= '0;
      tenth_q <= '0;
    end else begin
      tpt_q   <= tpt_d;
      tps_q   <= tps_d;
      tick_q  <= tick_d;
      tenth_q <= tenth_d;
    end
  end

endmodule

@@ rtl/pulse_input_counter_snapshot.sv @@
// Pulse input counter with periodic snapshot, top level.
// A tick transaction that ends a period puts its snapshot into the holding
// register, or into the skid entry when the output is stalled. Throughput:
// one transaction per cycle while in_stall_o is low; the lanes and dividers
// update on each accepted one; the two-entry output stage absorbs stalls.
// Reset: counts, arm flags and dividers clear, both dividers load 10.
module pulse_input_counter_snapshot #(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pic_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [pic_pkg::CfgDataBits-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [pic_pkg::NumOutputs-1:0]    pins_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pic_pkg::OutBits-1:0]       count_0_o,
  output logic [pic_pkg::OutBits-1:0]       count_1_o,
  output logic [pic_pkg::OutBits-1:0]       count_2_o,
  output logic [pic_pkg::OutBits-1:0]       count_3_o,
  output logic [pic_pkg::OutBits-1:0]       count_4_o,
  output logic [pic_pkg::OutBits-1:0]       count_5_o,
  output logic [pic_pkg::OutBits-1:0]       count_6_o,
  output logic [pic_pkg::OutBits-1:0]       count_7_o
);

  // channels beyond the output fields are never counted
  localparam int unsigned NumLanes =
    (NUM_CHANNELS < pic_pkg::NumOutputs) ? NUM_CHANNELS : pic_pkg::NumOutputs;

  pic_pkg::cfg_wr_t   cfg_wr;
  pic_pkg::lane_ctrl_t lane_ctrl;
  logic               in_fire;
  logic               tick;
  logic               emit;
  logic               out_fire;
  logic               lanes_zero;

  logic [pic_pkg::OutBits-1:0] snap   [pic_pkg::NumOutputs];
  logic [pic_pkg::OutBits-1:0] main_q [pic_pkg::NumOutputs];
  logic [pic_pkg::OutBits-1:0] skid_q [pic_pkg::NumOutputs];
  logic                        main_valid_q;
  logic                        skid_valid_q;

  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_i;
  assign cfg_wr.data = cfg_wdata_i;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign tick       = in_fire & (cmd_i == pic_pkg::CmdTick);

  assign lane_ctrl.sample = in_fire & (cmd_i == pic_pkg::CmdSample);
  assign lane_ctrl.clear  = emit;

  pic_timebase u_timebase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_wr),
    .tick_i (tick),
    .emit_o (emit)
  );

  for (genvar g = 0; g < pic_pkg::NumOutputs; g++) begin : g_lane
    if (g < NumLanes) begin : g_on
      pic_lane #(
        .COUNT_BITS (COUNT_BITS)
      ) u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (lane_ctrl),
        .pin_i  (pins_i[g]),
        .snap_o (snap[g])
      );
    end else begin : g_off
      assign snap[g] = '0;
    end
  end

  always_comb begin
    lanes_zero = 1'b1;
    for (int i = 0; i < pic_pkg::NumOutputs; i++) begin
      if (snap[i] != '0) lanes_zero = 1'b0;
    end
  end

  // output holding register with skid entry behind it
  assign out_fire = main_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!main_valid_q || out_fire) begin
        if (skid_valid_q) begin
          main_valid_q <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          main_valid_q <= emit;
        end
      end else if (emit) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || out_fire) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (emit) begin
        main_q <= snap;
      end
    end else if (emit) begin
      skid_q <= snap;
    end
  end

  assign out_valid_o = main_valid_q;
  assign count_0_o   = main_q[0];
  assign count_1_o   = main_q[1];
  assign count_2_o   = main_q[2];
  assign count_3_o   = main_q[3];
  assign count_4_o   = main_q[4];
  assign count_5_o   = main_q[5];
  assign count_6_o   = main_q[6];
  assign count_7_o   = main_q[7];

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry occupied while holding register empty");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !skid_valid_q)
    else $error("snapshot produced with no output entry free");

  a_stalled_emit_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && main_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("snapshot lost while output stalled");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> lanes_zero)
    else $error("lane counts not cleared after snapshot");

endmodule

@@ tb/sv/pic_tb_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the pulse input counter: predicts snapshots from accepted
// transactions and checks them against the block's output. Depends on pic_pkg.
package pic_tb_pkg;
  import pic_pkg::*;

  // index [ch] holds the count of channel ch
  typedef logic [NumOutputs-1:0][OutBits-1:0] snapshot_t;

  class pulse_count_scoreboard;
    logic [DivBits-1:0] ticks_per_tenth;
    logic [DivBits-1:0] tenths_per_second;
    logic [DivBits-1:0] tick_cnt;
    logic [DivBits-1:0] tenth_cnt;
    logic [NumOutputs-1:0] armed;
    logic [OutBits-1:0] counts [NumOutputs];
    snapshot_t snapshots_q[$];
    int unsigned errors;

    function new();
      ticks_per_tenth   = TicksPerTenthReset;
      tenths_per_second = TenthsPerSecondReset;
      tick_cnt  = '0;
      tenth_cnt = '0;
      armed     = '0;
      foreach (counts[ch]) counts[ch] = '0;
      errors = 0;
    endfunction

    function void write_divider(cfg_idx_e idx, logic [DivBits-1:0] value);
      case (idx)
        CfgTicksPerTenth: ticks_per_tenth = value;
        CfgTenthsPerSecond: tenths_per_second = value;
        default: ;
      endcase
    endfunction

    function void note_input(cmd_e cmd, logic [NumOutputs-1:0] pins);
      snapshot_t snap;
      if (cmd == CmdSample) begin
        for (int ch = 0; ch < NumOutputs; ch++) begin
          if (!pins[ch]) begin
            // count once per active period, rearm when the pin goes high
            if (!armed[ch]) begin
              armed[ch] = 1'b1;
              counts[ch] = counts[ch] + 1'b1;
            end
          end else begin
            armed[ch] = 1'b0;
          end
        end
      end else begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= ticks_per_tenth) begin
          tick_cnt = '0;
          tenth_cnt = tenth_cnt + 1'b1;
        end
        if (tenth_cnt >= tenths_per_second) begin
          tenth_cnt = '0;
          for (int ch = 0; ch < NumOutputs; ch++) begin
            snap[ch] = counts[ch];
            counts[ch] = '0;
          end
          snapshots_q.push_back(snap);
        end
      end
    endfunction

    function void check_snapshot(snapshot_t got);
      snapshot_t want;
      if (snapshots_q.size() == 0) begin
        $display("%0t: unexpected snapshot, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = snapshots_q.pop_front();
      for (int ch = 0; ch < NumOutputs; ch++) begin
        if (got[ch] !== want[ch]) begin
          $display("%0t: count_%0d mismatch, expected %0d, got %0d",
                   $time, ch, want[ch], got[ch]);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return snapshots_q.size();
    endfunction
  endclass

endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Top-level testbench for pulse_input_counter_snapshot: directed and random
// stimulus with random idling. Depends on pic_pkg and pic_tb_pkg.
module tb_top;
  import pic_pkg::*;
  import pic_tb_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned NumPhases  = 9;
  localparam int unsigned DrainCycles = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic cmd_i = 1'b0;
  logic [NumOutputs-1:0] pins_i = '1;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [OutBits-1:0] count_0_o, count_1_o, count_2_o, count_3_o;
  logic [OutBits-1:0] count_4_o, count_5_o, count_6_o, count_7_o;

  int unsigned send_idle_pct = 21;
  int unsigned recv_stall_pct = 80;
  int unsigned cycle_count = 0;

  pulse_count_scoreboard sb = new();

  // per phase: dividers, transaction count and share of ticks
  int unsigned phase_tpt[NumPhases]   = '{10, 0, 1, 255, 3, 1, 2, 0, 7};
  int unsigned phase_tps[NumPhases]   = '{10, 1, 0, 255, 2, 1, 5, 0, 3};
  int unsigned phase_items[NumPhases] = '{250, 150, 150, 200, 200, 150, 200, 100, 200};
  int unsigned phase_tick[NumPhases]  = '{60, 30, 30, 50, 40, 30, 50, 30, 60};

  pulse_input_counter_snapshot DUT (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .cmd_i, .pins_i,
    .out_valid_o, .out_stall_i,
    .count_0_o, .count_1_o, .count_2_o, .count_3_o,
    .count_4_o, .count_5_o, .count_6_o, .count_7_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_snapshot({count_7_o, count_6_o, count_5_o, count_4_o,
                         count_3_o, count_2_o, count_1_o, count_0_o});
    end
  end

  task automatic send_item(cmd_e cmd, logic [NumOutputs-1:0] pins);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    pins_i <= pins;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(cmd, pins);
  endtask

  // hold off the sender until every expected snapshot is out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_dividers(logic [DivBits-1:0] tpt, logic [DivBits-1:0] tps);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgTicksPerTenth;
    cfg_wdata_i <= tpt;
    @(posedge clk_i);
    sb.write_divider(CfgTicksPerTenth, tpt);
    cfg_idx_i <= CfgTenthsPerSecond;
    cfg_wdata_i <= tps;
    @(posedge clk_i);
    sb.write_divider(CfgTenthsPerSecond, tps);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [NumOutputs-1:0] pins;
    cmd_e cmd;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rearm rules, partial patterns, ticks with pins ignored
    send_item(CmdSample, 8'hFF);
    send_item(CmdSample, 8'h00);
    send_item(CmdSample, 8'h00);
    send_item(CmdSample, 8'hFF);
    send_item(CmdSample, 8'h00);
    send_item(CmdTick,   8'h00);
    send_item(CmdTick,   8'hFF);
    send_item(CmdSample, 8'hAA);
    send_item(CmdSample, 8'h55);
    send_item(CmdSample, 8'hFF);
    send_item(CmdSample, 8'hFE);
    send_item(CmdSample, 8'h7F);
    send_item(CmdTick,   8'h5A);
    send_item(CmdSample, 8'hFF);
    send_item(CmdSample, 8'h01);
    send_item(CmdTick,   8'hA5);

    pins = 8'hFF;
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      if (p < 3) begin
        send_idle_pct = 21;
        recv_stall_pct = 80;
      end else if (p < 6) begin
        send_idle_pct = 80;
        recv_stall_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      // first phase runs on the reset dividers
      if (p != 0) set_dividers(DivBits'(phase_tpt[p]), DivBits'(phase_tps[p]));
      for (int n = 0; n < phase_items[p]; n++) begin
        cmd = ($urandom_range(99) < phase_tick[p]) ? CmdTick : CmdSample;
        case ($urandom_range(3))
          0: pins = NumOutputs'($urandom);
          1: pins = 8'h00;
          2: pins = 8'hFF;
          default: pins = pins ^ (8'h01 << $urandom_range(7));
        endcase
        send_item(cmd, pins);
        if ($urandom_range(63) == 0) drain();
      end
    end

    // flush whatever is left in the counters with a single tick
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_dividers(8'd1, 8'd1);
    send_item(CmdTick, NumOutputs'($urandom));

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
